### rtl/point_transform_perspective_divide_top_defines.svh
// assertion helpers for the perspective divide block
`ifndef POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH
`define POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_DEFINES_SVH

// implication checked on every rising edge outside reset
`define PTPD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ptpd check failed");

// same check, also active during reset
`define PTPD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ptpd check failed");

`endif

### rtl/ptpd_pkg.sv
package ptpd_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 12;
  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int CFG_W   = 64;
  localparam int PROD_W  = COORD_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int NUM_W   = COORD_W + COORD_FRAC_BITS;
  localparam int REM_W   = COORD_W + 1;
  localparam int LANES   = 3;
  localparam int COLS    = 4;

  typedef enum logic [1:0] {
    REG_COL_X = 2'd0,
    REG_COL_Y = 2'd1,
    REG_COL_Z = 2'd2,
    REG_COL_W = 2'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] COEF_ONE  = CFG_W'(1) << COEF_FRAC_BITS;
  localparam logic [CFG_W-1:0] COL_X_RST = COEF_ONE;
  localparam logic [CFG_W-1:0] COL_Y_RST = COEF_ONE << COEF_W;
  localparam logic [CFG_W-1:0] COL_Z_RST = COEF_ONE << (2 * COEF_W);
  localparam logic [CFG_W-1:0] COL_W_RST = COEF_ONE << (3 * COEF_W);

  // transformed vector after rounding and clamping
  typedef struct packed {
    logic                             valid;
    logic                             sat;
    logic [COLS-1:0][COORD_W-1:0]     t;
  } xform_t;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic                             valid;
    logic                             sat;
    logic                             wz;
    logic [LANES-1:0]                 neg;
    logic [COORD_W-1:0]               div;
    logic [LANES-1:0][REM_W-1:0]      rem;
    logic [LANES-1:0][NUM_W-1:0]      nq;
  } cell_t;

endpackage

### rtl/ptpd_front.sv
module ptpd_front (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic signed [ptpd_pkg::COORD_W-1:0]           point_x_i,
  input  logic signed [ptpd_pkg::COORD_W-1:0]           point_y_i,
  input  logic signed [ptpd_pkg::COORD_W-1:0]           point_z_i,
  input  logic [ptpd_pkg::COLS-1:0][ptpd_pkg::CFG_W-1:0] cols_i,
  output ptpd_pkg::xform_t                              xf_o
);
  import ptpd_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] S_MIN = -(SUM_W'(1) <<< (COORD_W - 1));

  logic signed [PROD_W-1:0] prod_d [COLS][4];
  logic signed [PROD_W-1:0] prod_q [COLS][4];
  logic                     valid_a_q;
  logic signed [COEF_W-1:0] coef;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  xform_t                   xf_d, xf_q;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      for (int l = 0; l < 4; l++) begin
        coef = $signed(cols_i[c][COEF_W*l +: COEF_W]);
        unique case (l)
          0: prod_d[c][l] = PROD_W'(point_x_i) * PROD_W'(coef);
          1: prod_d[c][l] = PROD_W'(point_y_i) * PROD_W'(coef);
          2: prod_d[c][l] = PROD_W'(point_z_i) * PROD_W'(coef);
          default: prod_d[c][l] = PROD_W'(coef) <<< COORD_FRAC_BITS;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // sum, round half up, clamp
  always_comb begin
    xf_d = '0;
    xf_d.valid = valid_a_q;
    for (int c = 0; c < COLS; c++) begin
      sum = SUM_W'(prod_q[c][0]) + SUM_W'(prod_q[c][1]) + SUM_W'(prod_q[c][2])
          + SUM_W'(prod_q[c][3]) + ROUND_HALF;
      shifted = sum >>> COEF_FRAC_BITS;
      if (shifted > S_MAX) begin
        xf_d.t[c] = S_MAX[COORD_W-1:0];
        xf_d.sat  = 1'b1;
      end else if (shifted < S_MIN) begin
        xf_d.t[c] = S_MIN[COORD_W-1:0];
        xf_d.sat  = 1'b1;
      end else begin
        xf_d.t[c] = shifted[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xf_q <= '0;
    end else if (en_i) begin
      xf_q <= xf_d;
    end
  end

  assign xf_o = xf_q;

endmodule

### rtl/ptpd_cell.sv
module ptpd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  ptpd_pkg::cell_t cell_i,
  output ptpd_pkg::cell_t cell_o
);
  import ptpd_pkg::*;

  cell_t            cell_d, cell_q;
  logic [REM_W-1:0] trial;
  logic             ge;

  // one restoring quotient bit per lane
  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < LANES; l++) begin
      trial = {cell_i.rem[l][REM_W-2:0], cell_i.nq[l][NUM_W-1]};
      ge    = trial >= {1'b0, cell_i.div};
      cell_d.rem[l] = ge ? (trial - {1'b0, cell_i.div}) : trial;
      cell_d.nq[l]  = {cell_i.nq[l][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/point_transform_perspective_divide_top.sv
// pipeline from input transaction to result: 2 matrix stages, 1 divide setup,
//   48 divider cells one quotient bit each, 1 output register
// throughput: one point per cycle, the whole pipeline advances together when the
//   output register is empty or being taken
// reset: asynchronous active low, clears all valid bits and loads the identity matrix
`include "point_transform_perspective_divide_top_defines.svh"

module point_transform_perspective_divide_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [ptpd_pkg::CFG_W-1:0]           cfg_data_i,
  // point input channel
  input  logic                                 point_valid_i,
  output logic                                 point_ready_o,
  input  logic signed [ptpd_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [ptpd_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [ptpd_pkg::COORD_W-1:0]  point_z_i,
  // result output channel
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic signed [ptpd_pkg::COORD_W-1:0]  result_x_o,
  output logic signed [ptpd_pkg::COORD_W-1:0]  result_y_o,
  output logic signed [ptpd_pkg::COORD_W-1:0]  result_z_o,
  output logic                                 w_was_zero_o,
  output logic                                 saturated_o
);
  import ptpd_pkg::*;

  localparam logic [COORD_W-1:0] ONE_FIX = COORD_W'(1) << COORD_FRAC_BITS;
  localparam logic [NUM_W-1:0]   POS_MAX = NUM_W'(32'h7fffffff);
  localparam logic [NUM_W-1:0]   NEG_MAX = NUM_W'(1) << (COORD_W - 1);

  // matrix columns
  logic [COLS-1:0][CFG_W-1:0] cols_q;

  // global advance: output register empty or its transaction completes
  logic   en;
  xform_t xf;
  cell_t  chain [NUM_W+1];
  cell_t  prep_d, prep_q;
  logic   dneg;
  logic [COORD_W-1:0] tw;

  // output register
  logic                              out_valid_q;
  logic [LANES-1:0][COORD_W-1:0]     out_res_d, out_res_q;
  logic                              out_wz_q, out_sat_q, out_sat_d;
  logic [NUM_W-1:0]                  mag;

  assign en            = !out_valid_q || result_ready_i;
  assign point_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q[REG_COL_X] <= COL_X_RST;
      cols_q[REG_COL_Y] <= COL_Y_RST;
      cols_q[REG_COL_Z] <= COL_Z_RST;
      cols_q[REG_COL_W] <= COL_W_RST;
    end else if (cfg_we_i) begin
      cols_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // matrix multiply, rounding and clamp
  ptpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (point_valid_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .cols_i    (cols_q),
    .xf_o      (xf)
  );

  // divide setup: pick divisor, split signs from magnitudes
  always_comb begin
    prep_d       = '0;
    prep_d.valid = xf.valid;
    prep_d.sat   = xf.sat;
    tw           = xf.t[REG_COL_W];
    prep_d.wz    = (tw == '0);
    dneg         = tw[COORD_W-1];
    if (prep_d.wz) begin
      prep_d.div = ONE_FIX;
    end else begin
      prep_d.div = dneg ? (~tw + 1'b1) : tw;
    end
    for (int l = 0; l < LANES; l++) begin
      prep_d.neg[l] = xf.t[l][COORD_W-1] ^ dneg;
      prep_d.nq[l]  = {(xf.t[l][COORD_W-1] ? (~xf.t[l] + 1'b1) : xf.t[l]),
                       COORD_FRAC_BITS'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (en) begin
      prep_q <= prep_d;
    end
  end

  assign chain[0] = prep_q;

  // row of divider cells, one quotient bit each
  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    ptpd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // apply sign and clamp quotients
  always_comb begin
    out_sat_d = chain[NUM_W].sat;
    for (int l = 0; l < LANES; l++) begin
      mag = chain[NUM_W].nq[l];
      if (chain[NUM_W].neg[l]) begin
        if (mag > NEG_MAX) begin
          out_res_d[l] = NEG_MAX[COORD_W-1:0];
          out_sat_d    = 1'b1;
        end else begin
          out_res_d[l] = ~mag[COORD_W-1:0] + 1'b1;
        end
      end else if (mag > POS_MAX) begin
        out_res_d[l] = POS_MAX[COORD_W-1:0];
        out_sat_d    = 1'b1;
      end else begin
        out_res_d[l] = mag[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[NUM_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= out_res_d;
      out_wz_q  <= chain[NUM_W].wz;
      out_sat_q <= out_sat_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_x_o     = out_res_q[0];
  assign result_y_o     = out_res_q[1];
  assign result_z_o     = out_res_q[2];
  assign w_was_zero_o   = out_wz_q;
  assign saturated_o    = out_sat_q;

  `PTPD_ASSERT(a_hold_on_stall, clk_i, rst_ni, result_valid_o && !result_ready_i |=> result_valid_o && $stable(result_x_o) && $stable(w_was_zero_o))
  `PTPD_ASSERT(a_chain_to_out, clk_i, rst_ni, chain[NUM_W].valid && en |=> result_valid_o)
  `PTPD_ASSERT(a_chain_frozen, clk_i, rst_ni, !en |=> $stable(chain[0].valid) && $stable(chain[NUM_W].valid))
  `PTPD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !result_valid_o)

endmodule
